/* sv/wsd_pkg.sv */
// Shared types and constants for the frame deframer.
// Request structs for both channels and the status codes; no dependencies.
package wsd_pkg;

  // header bit positions and length codes
  localparam int unsigned FinBit      = 7;
  localparam int unsigned MaskBit     = 7;
  localparam logic [6:0]  LenCodeExt  = 7'd126;
  localparam logic [6:0]  LenCodeLong = 7'd127;
  localparam logic [2:0]  ExtBytes    = 3'd2;
  localparam logic [2:0]  KeyBytes    = 3'd4;

  // status reported with a result
  typedef enum logic [1:0] {
    ST_NONE        = 2'd0,
    ST_DONE        = 2'd1,
    ST_INCOMPLETE  = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_e;

  // one received byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_t;

  // one result
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        payload_valid;
    status_e     frame_status;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [15:0] payload_length;
    logic [16:0] total_len;
  } out_t;

endpackage

/* sv/wsd_core.sv */
// Frame parser state and per-byte decode: header, extended length, mask key,
// payload unmasking. Depends on wsd_pkg.
module wsd_core
  import wsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  in_t  item_i,
  output logic res_valid_o,
  output out_t res_o
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4,
    PH_DROP = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [15:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [15:0] pay_cnt_q, pay_cnt_d;
  logic [3:0]  hdr_len_q, hdr_len_d;

  logic [7:0]  b;
  logic        last;
  logic        hdr_done;
  logic        go_pay;
  logic [7:0]  key_byte;
  logic [7:0]  ob;
  logic        pv;
  status_e     st;
  logic [16:0] raw;

  assign b = item_i.data_byte;

  // next state and result for the byte in the input register
  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    len_d     = len_q;
    key_d     = key_q;
    pay_cnt_d = pay_cnt_q;
    hdr_len_d = hdr_len_q;
    last      = item_i.buffer_end;
    hdr_done  = 1'b0;
    go_pay    = 1'b0;
    key_byte  = 8'h00;
    ob        = 8'h00;
    pv        = 1'b0;
    st        = ST_NONE;
    raw       = 17'd0;

    unique case (phase_q)
      PH_HDR1: begin
        mask_d    = b[MaskBit];
        len_d     = {9'd0, b[6:0]};
        hdr_len_d = 4'd2;
        if (b[6:0] == LenCodeLong) begin
          st      = ST_UNSUPPORTED;
          phase_d = last ? PH_HDR0 : PH_DROP;
          last    = 1'b0;
        end else if (b[6:0] == LenCodeExt) begin
          phase_d   = PH_EXT;
          hdr_idx_d = 3'd0;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_EXT: begin
        len_d     = {len_q[7:0], b};
        hdr_idx_d = hdr_idx_q + 3'd1;
        hdr_len_d = hdr_len_q + 4'd1;
        hdr_done  = (hdr_idx_d >= ExtBytes);
      end
      PH_KEY: begin
        key_d     = {key_q[23:0], b};
        hdr_idx_d = hdr_idx_q + 3'd1;
        hdr_len_d = hdr_len_q + 4'd1;
        go_pay    = (hdr_idx_d >= KeyBytes);
      end
      PH_PAY: begin
        // key byte 0 is the first key byte received
        if (mask_q) begin
          case (pay_cnt_q[1:0])
            2'd0:    key_byte = key_q[31:24];
            2'd1:    key_byte = key_q[23:16];
            2'd2:    key_byte = key_q[15:8];
            default: key_byte = key_q[7:0];
          endcase
        end
        ob        = b ^ key_byte;
        pv        = 1'b1;
        pay_cnt_d = pay_cnt_q + 16'd1;
        if (pay_cnt_d == len_q) begin
          st      = ST_DONE;
          phase_d = PH_HDR0;
        end
      end
      PH_DROP: begin
        // discard until the buffer ends, no results
        if (last) phase_d = PH_HDR0;
        last = 1'b0;
      end
      default: begin
        fin_d     = b[FinBit];
        opcode_d  = b[3:0];
        mask_d    = 1'b0;
        len_d     = 16'd0;
        key_d     = 32'd0;
        pay_cnt_d = 16'd0;
        hdr_idx_d = 3'd0;
        hdr_len_d = 4'd1;
        phase_d   = PH_HDR1;
      end
    endcase

    // header finished: key next, or straight to payload
    if (hdr_done) begin
      if (mask_d) begin
        phase_d   = PH_KEY;
        hdr_idx_d = 3'd0;
      end else begin
        go_pay = 1'b1;
      end
    end

    // empty payload completes right away
    if (go_pay) begin
      if (len_d == 16'd0) begin
        phase_d = PH_HDR0;
        st      = ST_DONE;
      end else begin
        phase_d = PH_PAY;
      end
    end

    // completion wins over buffer end
    if (st == ST_DONE) begin
      raw = {13'd0, hdr_len_d} + {1'b0, len_d};
    end else if (last && (st == ST_NONE)) begin
      st      = ST_INCOMPLETE;
      phase_d = PH_HDR0;
    end
  end

  assign res_valid_o          = pv || (st != ST_NONE);
  assign res_o.out_byte       = ob;
  assign res_o.payload_valid  = pv;
  assign res_o.frame_status   = st;
  assign res_o.fin_flag       = fin_d;
  assign res_o.frame_opcode   = opcode_d;
  assign res_o.was_masked     = mask_d;
  assign res_o.payload_length = len_d;
  assign res_o.total_len      = raw;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      hdr_idx_q <= 3'd0;
      fin_q     <= 1'b0;
      opcode_q  <= 4'd0;
      mask_q    <= 1'b0;
      len_q     <= 16'd0;
      key_q     <= 32'd0;
      pay_cnt_q <= 16'd0;
      hdr_len_q <= 4'd0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      fin_q     <= fin_d;
      opcode_q  <= opcode_d;
      mask_q    <= mask_d;
      len_q     <= len_d;
      key_q     <= key_d;
      pay_cnt_q <= pay_cnt_d;
      hdr_len_q <= hdr_len_d;
    end
  end

endmodule

/* sv/websocket_frame_deframer.sv */
// Top level of the frame deframer: input register, parser core, result register.
// Depends on wsd_pkg and wsd_core.
//
//   channel | direction | handshake              | request type
//   in      | input     | in_valid_i/in_ready_o  | in_t  (data_byte, buffer_end)
//   out     | output    | out_valid_o/out_ready_i| out_t (payload byte, status, header)
//
// One byte per cycle sustained while the result register is not stalled; a byte
// waits in the input register and its result is then registered in the result register.
// The parser state advances once per byte as it leaves the input register.
// Bytes that cause no result are consumed without touching the result register.
// A stalled result register holds the input register; input stays ready while
// the input register is empty. Reset returns the parser to the first header byte.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  logic advance;
  logic in_fire;
  logic res_valid;
  out_t res;

  // the input register moves on when the result register can take a request
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_data_i;
    end
  end

  wsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a result always carries a byte or a status
  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.payload_valid || (out_data_o.frame_status != ST_NONE)))
    else $error("result with neither payload nor status");

  // unsupported length never comes with a payload byte
  a_unsup_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.payload_valid) |->
      (out_data_o.frame_status != ST_UNSUPPORTED))
    else $error("payload byte with unsupported status");

  // raw length only on completion, and covers at least the two header bytes
  a_raw_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.frame_status != ST_DONE)) |->
      (out_data_o.total_len == 17'd0))
    else $error("raw length without completion");

  a_raw_covers_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.frame_status == ST_DONE)) |->
      (out_data_o.total_len >= ({1'b0, out_data_o.payload_length} + 17'd2)))
    else $error("raw length shorter than header plus payload");

  // input stalls only when both registers are full
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

endmodule

/* test/deframer_checker.sv */
// Checker for the frame deframer: watches both channels, predicts each result
// from the accepted bytes and compares it field by field. Depends on wsd_pkg.
module deframer_checker
  import wsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o,
  output int   frames_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // where the parser stands inside a frame
  typedef enum logic [2:0] {
    AT_FIRST   = 3'd0,
    AT_SECOND  = 3'd1,
    AT_EXTLEN  = 3'd2,
    AT_KEY     = 3'd3,
    AT_PAYLOAD = 3'd4,
    AT_SKIP    = 3'd5
  } parse_e;

  parse_e      where_q;
  logic [3:0]  hdr_pos;
  logic        fin_q;
  logic [3:0]  opcode_q;
  logic        masked_q;
  logic [15:0] len_q;
  logic [31:0] key_q;
  logic [15:0] pay_pos;
  logic [3:0]  hdr_bytes;

  // predicted results not yet seen on the output
  out_t unmasked_q[$];

  // header and key done: empty frames finish here
  function automatic status_e open_payload();
    if (len_q == 16'd0) begin
      where_q = AT_FIRST;
      return ST_DONE;
    end
    where_q = AT_PAYLOAD;
    return ST_NONE;
  endfunction

  function automatic status_e close_header();
    if (masked_q) begin
      where_q = AT_KEY;
      hdr_pos = 4'd0;
      return ST_NONE;
    end
    return open_payload();
  endfunction

  // advance the parser by one byte and queue the result it causes
  task automatic deframe_byte(input in_t req);
    out_t       res;
    status_e    st;
    logic       last;
    logic       emit;
    logic       discard;
    logic [7:0] key_byte;
    res      = '0;
    st       = ST_NONE;
    last     = req.buffer_end;
    emit     = 1'b0;
    discard  = 1'b0;
    key_byte = 8'd0;
    case (where_q)
      AT_SECOND: begin
        masked_q  = req.data_byte[MaskBit];
        len_q     = {9'd0, req.data_byte[6:0]};
        hdr_bytes = 4'd2;
        if (req.data_byte[6:0] == LenCodeLong) begin
          st      = ST_UNSUPPORTED;
          where_q = last ? AT_FIRST : AT_SKIP;
          last    = 1'b0;
        end else if (req.data_byte[6:0] == LenCodeExt) begin
          where_q = AT_EXTLEN;
          hdr_pos = 4'd0;
        end else begin
          st = close_header();
        end
      end
      AT_EXTLEN: begin
        len_q     = {len_q[7:0], req.data_byte};
        hdr_pos   = hdr_pos + 4'd1;
        hdr_bytes = hdr_bytes + 4'd1;
        if (hdr_pos >= 4'(ExtBytes)) st = close_header();
      end
      AT_KEY: begin
        key_q     = {key_q[23:0], req.data_byte};
        hdr_pos   = hdr_pos + 4'd1;
        hdr_bytes = hdr_bytes + 4'd1;
        if (hdr_pos >= 4'(KeyBytes)) st = open_payload();
      end
      AT_PAYLOAD: begin
        // first key byte received pairs with payload byte 0
        if (masked_q) key_byte = key_q[8 * (3 - pay_pos[1:0]) +: 8];
        res.out_byte = req.data_byte ^ key_byte;
        emit         = 1'b1;
        pay_pos      = pay_pos + 16'd1;
        if (pay_pos == len_q) begin
          st      = ST_DONE;
          where_q = AT_FIRST;
        end
      end
      AT_SKIP: begin
        // rest of a 64-bit length frame is dropped up to the buffer end
        discard = 1'b1;
        if (last) where_q = AT_FIRST;
      end
      default: begin
        fin_q     = req.data_byte[FinBit];
        opcode_q  = req.data_byte[3:0];
        masked_q  = 1'b0;
        len_q     = 16'd0;
        key_q     = 32'd0;
        pay_pos   = 16'd0;
        hdr_pos   = 4'd0;
        hdr_bytes = 4'd1;
        where_q   = AT_SECOND;
      end
    endcase

    if (!discard) begin
      if (st == ST_DONE) begin
        res.total_len = 17'(hdr_bytes) + 17'(len_q);
      end else if (last && st == ST_NONE) begin
        st      = ST_INCOMPLETE;
        where_q = AT_FIRST;
      end
      if (emit || st != ST_NONE) begin
        res.payload_valid  = emit;
        res.frame_status   = st;
        res.fin_flag       = fin_q;
        res.frame_opcode   = opcode_q;
        res.was_masked     = masked_q;
        res.payload_length = len_q;
        unmasked_q.push_back(res);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  // compare results first, then predict from the byte taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      where_q      = AT_FIRST;
      hdr_pos      = 4'd0;
      fin_q        = 1'b0;
      opcode_q     = 4'd0;
      masked_q     = 1'b0;
      len_q        = 16'd0;
      key_q        = 32'd0;
      pay_pos      = 16'd0;
      hdr_bytes    = 4'd0;
      unmasked_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      frames_o     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (out_data_i.frame_status == ST_DONE) frames_o++;
        if (unmasked_q.size() == 0) begin
          $error("result with nothing expected: %p", out_data_i);
          fail_count_o++;
        end else begin
          want = unmasked_q.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_data_i.out_byte));
          check_field("payload_valid", 32'(want.payload_valid),
                      32'(out_data_i.payload_valid));
          check_field("frame_status", 32'(want.frame_status),
                      32'(out_data_i.frame_status));
          check_field("fin_flag", 32'(want.fin_flag), 32'(out_data_i.fin_flag));
          check_field("frame_opcode", 32'(want.frame_opcode),
                      32'(out_data_i.frame_opcode));
          check_field("was_masked", 32'(want.was_masked), 32'(out_data_i.was_masked));
          check_field("payload_length", 32'(want.payload_length),
                      32'(out_data_i.payload_length));
          check_field("total_len", 32'(want.total_len), 32'(out_data_i.total_len));
        end
      end
      if (in_valid_i && in_ready_i) deframe_byte(in_data_i);
      pending_o = unmasked_q.size();
    end
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the frame deframer: clock, reset, byte stream stimulus
// and the final verdict. Depends on wsd_pkg, websocket_frame_deframer, deframer_checker.
module tb_top;
  import wsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // frame opcodes used by the directed part
  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'hA;
  localparam logic [3:0] OpTop   = 4'hF;
  localparam int NoEnd = -1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic idle_on = 1'b1;

  int items_sent = 0;
  int fail_count;
  int pending;
  int results_seen;
  int frames_done;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  websocket_frame_deframer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  deframer_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results_seen),
    .frames_o    (frames_done)
  );

  // receiver stalls now and then, except during the quiet stretch
  always @(negedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 7) : 1'b1;
  end

  // one byte request, held until taken
  task automatic send_req(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (idle_on && ($urandom_range(99) < 7)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, buffer_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // one frame; the byte at stop_at carries buffer end and the rest is cut off
  task automatic send_frame(input logic fin_b, input logic [3:0] opc, input logic masked,
                            input int unsigned len, input logic ext, input int stop_at);
    logic [7:0] fq[$];
    logic [2:0] rsv;
    rsv = 3'($urandom_range(7));
    fq.push_back({fin_b, rsv, opc});
    if (ext) begin
      fq.push_back({masked, LenCodeExt});
      fq.push_back(len[15:8]);
      fq.push_back(len[7:0]);
    end else begin
      fq.push_back({masked, len[6:0]});
    end
    if (masked) repeat (4) fq.push_back(8'($urandom_range(255)));
    repeat (len) fq.push_back(8'($urandom_range(255)));
    for (int i = 0; i < fq.size(); i++) begin
      if (stop_at != NoEnd && i > stop_at) break;
      send_req(fq[i], i == stop_at);
    end
  endtask

  // frame with a 64-bit length code and its discarded tail
  task automatic send_long(input int tail);
    logic [2:0] rsv;
    rsv = 3'($urandom_range(7));
    send_req({1'($urandom_range(1)), rsv, 4'($urandom_range(15))}, 1'b0);
    send_req({1'($urandom_range(1)), LenCodeLong}, tail == 0);
    for (int i = 0; i < tail; i++) send_req(8'($urandom_range(255)), i == tail - 1);
  endtask

  // random bytes, closed by a buffer end so the next frame starts clean
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_req(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(9) == 0));
    end
  endtask

  initial begin
    int unsigned len;
    int          pick;
    int          drain;
    logic        ext;
    logic        masked;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty frames, short and extended lengths, truncations
    send_frame(1'b1, OpText, 1'b0, 0, 1'b0, NoEnd);
    send_frame(1'b0, OpBin, 1'b1, 0, 1'b0, NoEnd);
    send_frame(1'b1, OpCont, 1'b0, 3, 1'b0, NoEnd);
    send_frame(1'b1, OpText, 1'b1, 6, 1'b0, NoEnd);
    send_frame(1'b1, OpPing, 1'b0, 125, 1'b0, NoEnd);
    send_frame(1'b1, OpClose, 1'b1, 0, 1'b1, NoEnd);
    send_frame(1'b0, OpPong, 1'b0, 130, 1'b1, NoEnd);
    send_frame(1'b1, OpTop, 1'b1, 65535, 1'b1, 3);
    send_frame(1'b1, OpText, 1'b0, 300, 1'b1, 2);
    send_frame(1'b1, OpText, 1'b0, 5, 1'b0, 0);
    send_frame(1'b1, OpBin, 1'b1, 5, 1'b0, 4);
    send_frame(1'b0, OpText, 1'b1, 9, 1'b0, 8);
    send_frame(1'b1, OpBin, 1'b0, 4, 1'b0, 5);
    send_long(0);
    send_long(3);
    send_frame(1'b1, OpText, 1'b1, 1, 1'b0, NoEnd);

    // random: mostly well-formed frames, some cut short, long codes and noise
    while (items_sent < 2000) begin
      idle_on = !(items_sent >= 800 && items_sent < 1300);
      pick = $urandom_range(99);
      if (pick < 75) begin
        ext    = 1'b0;
        masked = 1'($urandom_range(1));
        if ($urandom_range(99) < 70) len = $urandom_range(12);
        else if ($urandom_range(99) < 70) len = $urandom_range(125, 13);
        else begin
          ext = 1'b1;
          len = $urandom_range(400);
        end
        if (pick < 55) begin
          send_frame(1'($urandom_range(1)), 4'($urandom_range(15)), masked, len, ext,
                     ($urandom_range(2) == 0) ? 1000000 : NoEnd);
        end else begin
          send_frame(1'($urandom_range(1)), 4'($urandom_range(15)), masked, len, ext,
                     int'($urandom_range(len + 9)));
        end
      end else if (pick < 85) begin
        send_long(int'($urandom_range(6)));
      end else begin
        send_noise(int'($urandom_range(8, 1)));
      end
    end

    idle_on = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);

    $display("stream of %0d bytes gave %0d checked results, %0d of them finished frames",
             items_sent, results_seen, frames_done);
    $display("covered empty, masked, extended, truncated and 64-bit length frames");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #24_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
sv/wsd_pkg.sv
sv/wsd_core.sv
sv/websocket_frame_deframer.sv
test/deframer_checker.sv
test/tb_top.sv
